/* design/i2a_pkg.sv */
`default_nettype none

package i2a_pkg;

    // conversion kinds
    localparam logic [2:0] FUNC_OCT    = 3'd0;
    localparam logic [2:0] FUNC_UDEC   = 3'd1;
    localparam logic [2:0] FUNC_SDEC   = 3'd2;
    localparam logic [2:0] FUNC_HEX_UP = 3'd3;
    localparam logic [2:0] FUNC_HEX_LO = 3'd4;

    // flag bit positions
    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_SPACE = 2;
    localparam int FLAG_ALT   = 3;
    localparam int FLAG_ZERO  = 4;

    // ASCII codes
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_LOWER_BIT = 8'h20;

    // controller states; emitting states run in output order
    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_CONV   = 4'd1,
        ST_SETUP  = 4'd2,
        ST_LEAD   = 4'd3,
        ST_SIGN   = 4'd4,
        ST_PFX0   = 4'd5,
        ST_PFXX   = 4'd6,
        ST_ZPAD   = 4'd7,
        ST_PREC   = 4'd8,
        ST_DIGITS = 4'd9,
        ST_TRAIL  = 4'd10
    } t_i2a_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       setup;
        logic       emit;
        logic       last;
        t_i2a_state phase;
    } t_i2a_cmd;

    // datapath -> controller
    typedef struct packed {
        logic conv_last;
        logic out_free;
        logic lead_nz;
        logic lead_last;
        logic has_sign;
        logic pfx_any;
        logic pfx_hex;
        logic zpad_nz;
        logic zpad_last;
        logic prec_nz;
        logic prec_last;
        logic dig_last;
        logic trail_nz;
        logic trail_last;
    } t_i2a_status;

    // digit value to upper-case character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'b0, d};
        end else begin
            c = CH_UPPER_A - 8'd10 + {4'b0, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/i2a_ctrl.sv */
`default_nettype none

module i2a_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire i2a_pkg::t_i2a_status  i_status,
    output i2a_pkg::t_i2a_cmd          o_cmd,
    output logic                       o_busy
);

    i2a_pkg::t_i2a_state r_state;
    i2a_pkg::t_i2a_state n_state;

    // first non-empty phase at or after s (digits are never empty)
    function automatic i2a_pkg::t_i2a_state first_from(
        input i2a_pkg::t_i2a_state  s,
        input i2a_pkg::t_i2a_status st
    );
        i2a_pkg::t_i2a_state r;
        r = i2a_pkg::ST_DIGITS;
        if (s <= i2a_pkg::ST_PREC && st.prec_nz) r = i2a_pkg::ST_PREC;
        if (s <= i2a_pkg::ST_ZPAD && st.zpad_nz) r = i2a_pkg::ST_ZPAD;
        if (s <= i2a_pkg::ST_PFX0 && st.pfx_any) r = i2a_pkg::ST_PFX0;
        if (s <= i2a_pkg::ST_SIGN && st.has_sign) r = i2a_pkg::ST_SIGN;
        return r;
    endfunction

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2a_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.phase = r_state;
        case (r_state)
            i2a_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i2a_pkg::ST_CONV;
                end
            end
            i2a_pkg::ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_status.conv_last) n_state = i2a_pkg::ST_SETUP;
            end
            i2a_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i2a_pkg::ST_LEAD;
            end
            i2a_pkg::ST_LEAD: begin
                // an empty lead phase just passes through
                if (!i_status.lead_nz) begin
                    n_state = first_from(i2a_pkg::ST_SIGN, i_status);
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.lead_last) n_state = first_from(i2a_pkg::ST_SIGN, i_status);
                end
            end
            i2a_pkg::ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = first_from(i2a_pkg::ST_PFX0, i_status);
                end
            end
            i2a_pkg::ST_PFX0: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.pfx_hex ? i2a_pkg::ST_PFXX
                                                  : first_from(i2a_pkg::ST_ZPAD, i_status);
                end
            end
            i2a_pkg::ST_PFXX: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = first_from(i2a_pkg::ST_ZPAD, i_status);
                end
            end
            i2a_pkg::ST_ZPAD: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.zpad_last) n_state = first_from(i2a_pkg::ST_PREC, i_status);
                end
            end
            i2a_pkg::ST_PREC: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.prec_last) n_state = i2a_pkg::ST_DIGITS;
                end
            end
            i2a_pkg::ST_DIGITS: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_status.dig_last && !i_status.trail_nz;
                    if (i_status.dig_last) begin
                        n_state = i_status.trail_nz ? i2a_pkg::ST_TRAIL : i2a_pkg::ST_IDLE;
                    end
                end
            end
            i2a_pkg::ST_TRAIL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_status.trail_last;
                    if (i_status.trail_last) n_state = i2a_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != i2a_pkg::ST_IDLE);

endmodule

`default_nettype wire

/* design/i2a_dpath.sv */
`default_nettype none

module i2a_dpath #(
    parameter int VALUE_BITS  = 32,
    parameter int DIGIT_SLOTS = 11,
    parameter int MAX_FIELD   = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire i2a_pkg::t_i2a_cmd     i_cmd,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [2:0]            i_func,
    input  wire logic [4:0]            i_format_flags,
    input  wire logic [5:0]            i_field_width,
    input  wire logic [5:0]            i_precision,
    input  wire logic                  i_stall,
    output i2a_pkg::t_i2a_status       o_status,
    output logic                       o_valid,
    output logic [7:0]                 o_out_char,
    output logic                       o_last_char
);

    localparam int VB = VALUE_BITS;
    localparam int S  = DIGIT_SLOTS;
    localparam int IW = $clog2(S);
    localparam int NW = $clog2(S + 1);
    localparam int BW = $clog2(VB + 1);

    // item registers
    logic [VB-1:0]       r_value;
    logic [BW-1:0]       r_bits;
    logic [S-1:0][3:0]   r_digits;
    logic [NW-1:0]       r_ndig;
    logic                r_is_dec;
    logic                r_is_hex;
    logic                r_lower;
    logic                r_left;
    logic                r_zp;
    logic [7:0]          r_sign_ch;
    logic                r_has_sign;
    logic                r_pfx_any;
    logic                r_pfx_hex;
    logic [5:0]          r_w;
    logic [5:0]          r_p;
    logic [5:0]          r_lead;
    logic [5:0]          r_zpad;
    logic [5:0]          r_prec;
    logic [5:0]          r_trail;
    logic [NW-1:0]       r_didx;
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    // input decode
    logic                is_oct_in;
    logic                is_hex_in;
    logic                is_sdec_in;
    logic                neg_in;
    logic [VB-1:0]       mag_in;
    logic [5:0]          w_sat;
    logic [5:0]          p_sat;
    logic [7:0]          sign_ch_in;
    logic                has_sign_in;
    logic                left_in;
    // octal/hex step
    logic [3:0]          shf_digit;
    logic [VB-1:0]       shf_value;
    // decimal shift-add-3 step
    logic [S-1:0][3:0]   dec_adj;
    logic [S*4-1:0]      adj_flat;
    logic [S-1:0][3:0]   dec_next;
    logic                dec_hit;
    // setup
    logic [NW-1:0]       eff_n;
    logic [5:0]          n6;
    logic [5:0]          body6;
    logic [6:0]          pfx7;
    logic [6:0]          used7;
    logic [5:0]          pad6;
    // emit
    logic [NW-1:0]       didx_m1;
    logic [7:0]          lower_mask;
    logic [7:0]          emit_char;
    logic                out_free;

    // decode of the incoming item
    always_comb begin
        is_oct_in  = (i_func == i2a_pkg::FUNC_OCT);
        is_hex_in  = (i_func == i2a_pkg::FUNC_HEX_UP) || (i_func == i2a_pkg::FUNC_HEX_LO);
        is_sdec_in = (i_func == i2a_pkg::FUNC_SDEC);
        neg_in     = is_sdec_in && i_value[VB-1];
        mag_in     = neg_in ? (VB'(0) - i_value) : i_value;
        w_sat      = (i_field_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : i_field_width;
        p_sat      = (i_precision > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : i_precision;
        left_in    = i_format_flags[i2a_pkg::FLAG_LEFT];
        // minus beats plus beats space
        has_sign_in = neg_in || (is_sdec_in && (i_format_flags[i2a_pkg::FLAG_PLUS] ||
                                                i_format_flags[i2a_pkg::FLAG_SPACE]));
        if (neg_in) begin
            sign_ch_in = i2a_pkg::CH_MINUS;
        end else if (i_format_flags[i2a_pkg::FLAG_PLUS]) begin
            sign_ch_in = i2a_pkg::CH_PLUS;
        end else begin
            sign_ch_in = i2a_pkg::CH_SPACE;
        end
    end

    // octal/hex: peel one digit off the bottom per cycle
    always_comb begin
        shf_digit = r_is_hex ? r_value[3:0] : {1'b0, r_value[2:0]};
        shf_value = r_is_hex ? (r_value >> 4) : (r_value >> 3);
    end

    // decimal: one bit of double dabble per cycle
    always_comb begin
        for (int k = 0; k < S; k++) begin
            dec_adj[k] = (r_digits[k] >= 4'd5) ? (r_digits[k] + 4'd3) : r_digits[k];
        end
        adj_flat = dec_adj;
        dec_next = {adj_flat[S*4-2:0], r_value[VB-1]};
        // the digit count grows by at most one per doubling
        dec_hit  = (r_ndig < NW'(S)) && (dec_next[r_ndig[IW-1:0]] != 4'd0);
    end

    // field layout
    always_comb begin
        eff_n = (r_ndig == '0) ? NW'(1) : r_ndig;
        n6    = 6'(eff_n);
        body6 = (r_p > n6) ? r_p : n6;
        pfx7  = r_pfx_hex ? 7'd2 : (r_pfx_any ? 7'd1 : 7'd0);
        used7 = {1'b0, body6} + {6'b0, r_has_sign} + pfx7;
        pad6  = ({1'b0, r_w} > used7) ? 6'({1'b0, r_w} - used7) : 6'd0;
    end

    // character for the current phase
    always_comb begin
        didx_m1    = r_didx - NW'(1);
        lower_mask = r_lower ? i2a_pkg::CH_LOWER_BIT : 8'h00;
        case (i_cmd.phase)
            i2a_pkg::ST_SIGN:                   emit_char = r_sign_ch;
            i2a_pkg::ST_PFX0, i2a_pkg::ST_ZPAD,
            i2a_pkg::ST_PREC:                   emit_char = i2a_pkg::CH_ZERO;
            i2a_pkg::ST_PFXX:                   emit_char = i2a_pkg::CH_UPPER_X | lower_mask;
            i2a_pkg::ST_DIGITS: begin
                emit_char = i2a_pkg::digit_char(r_digits[didx_m1[IW-1:0]]) | lower_mask;
            end
            default:                            emit_char = i2a_pkg::CH_SPACE;
        endcase
    end

    assign out_free = !r_out_valid || !i_stall;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value    <= mag_in;
            r_bits     <= BW'(VB);
            r_digits   <= '0;
            r_is_dec   <= !is_oct_in && !is_hex_in;
            r_is_hex   <= is_hex_in;
            r_lower    <= (i_func == i2a_pkg::FUNC_HEX_LO);
            r_left     <= left_in;
            r_zp       <= i_format_flags[i2a_pkg::FLAG_ZERO] && !left_in;
            r_sign_ch  <= sign_ch_in;
            r_has_sign <= has_sign_in;
            r_pfx_any  <= i_format_flags[i2a_pkg::FLAG_ALT] && (is_oct_in || is_hex_in);
            r_pfx_hex  <= i_format_flags[i2a_pkg::FLAG_ALT] && is_hex_in;
            r_w        <= w_sat;
            r_p        <= p_sat;
        end else if (i_cmd.conv_step) begin
            if (r_is_dec) begin
                r_digits <= dec_next;
                r_value  <= r_value << 1;
                r_bits   <= r_bits - BW'(1);
            end else begin
                r_digits[r_ndig[IW-1:0]] <= shf_digit;
                r_value                  <= shf_value;
            end
        end
        if (i_cmd.emit) begin
            r_out_char <= emit_char;
            r_out_last <= i_cmd.last;
        end
    end

    // counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndig      <= '0;
            r_didx      <= '0;
            r_lead      <= '0;
            r_zpad      <= '0;
            r_prec      <= '0;
            r_trail     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ndig <= '0;
            end else if (i_cmd.conv_step) begin
                if (r_is_dec) begin
                    if (dec_hit) r_ndig <= r_ndig + NW'(1);
                end else begin
                    r_ndig <= r_ndig + NW'(1);
                end
            end else if (i_cmd.setup) begin
                r_ndig  <= eff_n;
                r_didx  <= eff_n;
                r_lead  <= (!r_left && !r_zp) ? pad6 : 6'd0;
                r_zpad  <= r_zp ? pad6 : 6'd0;
                r_trail <= r_left ? pad6 : 6'd0;
                r_prec  <= body6 - n6;
            end
            // count down the phase that just sent a beat
            if (i_cmd.emit) begin
                case (i_cmd.phase)
                    i2a_pkg::ST_LEAD:   r_lead  <= r_lead - 6'd1;
                    i2a_pkg::ST_ZPAD:   r_zpad  <= r_zpad - 6'd1;
                    i2a_pkg::ST_PREC:   r_prec  <= r_prec - 6'd1;
                    i2a_pkg::ST_DIGITS: r_didx  <= didx_m1;
                    i2a_pkg::ST_TRAIL:  r_trail <= r_trail - 6'd1;
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // status to the controller
    always_comb begin
        o_status.conv_last  = r_is_dec ? (r_bits == BW'(1))
                                       : ((shf_value == '0) || (r_ndig == NW'(S - 1)));
        o_status.out_free   = out_free;
        o_status.lead_nz    = (r_lead != 6'd0);
        o_status.lead_last  = (r_lead == 6'd1);
        o_status.has_sign   = r_has_sign;
        o_status.pfx_any    = r_pfx_any;
        o_status.pfx_hex    = r_pfx_hex;
        o_status.zpad_nz    = (r_zpad != 6'd0);
        o_status.zpad_last  = (r_zpad == 6'd1);
        o_status.prec_nz    = (r_prec != 6'd0);
        o_status.prec_last  = (r_prec == 6'd1);
        o_status.dig_last   = (r_didx == NW'(1));
        o_status.trail_nz   = (r_trail != 6'd0);
        o_status.trail_last = (r_trail == 6'd1);
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

`default_nettype wire

/* design/integer_to_padded_ascii.sv */
// Flow: the item is taken, then its octal/hex digits are peeled off (up to
//   DIGIT_SLOTS) or VALUE_BITS shift-add-3 steps run for decimal, then setup
//   (and the empty lead state if there are no leading spaces), then one character
//   per cycle while the output is not stalled. One conversion at a time, up to 50
//   characters; the next item is taken once the last beat is in the output
//   register. Reset: synchronous, active low; clears controller and output valid.
`default_nettype none

module integer_to_padded_ascii #(
    parameter int VALUE_BITS  = 32,
    parameter int DIGIT_SLOTS = 11,
    parameter int MAX_FIELD   = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [2:0]            i_func,
    input  wire logic [4:0]            i_format_flags,
    input  wire logic [5:0]            i_field_width,
    input  wire logic [5:0]            i_precision,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [7:0]                 o_out_char,
    output logic                       o_last_char
);

    i2a_pkg::t_i2a_cmd    cmd;
    i2a_pkg::t_i2a_status status;
    logic                 busy;

    i2a_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    i2a_dpath #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_SLOTS (DIGIT_SLOTS),
        .MAX_FIELD   (MAX_FIELD)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .i_func         (i_func),
        .i_format_flags (i_format_flags),
        .i_field_width  (i_field_width),
        .i_precision    (i_precision),
        .i_stall        (i_stall),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char)
    );

    // input side is open only between conversions
    assign o_stall = busy;

endmodule

`default_nettype wire

/* design/i2a_chk.sv */
`default_nettype none

module i2a_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_stall,
    input wire logic       i_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] i_out_char,
    input wire logic       i_out_last
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_char) &&
                                       $stable(i_out_last))
        else $error("output beat changed under stall");

    // one conversion at a time: input closes after a taken beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input open right after an accepted beat");

    // while the input is open, a pending output can only be a final character
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_stall && i_out_valid |-> i_out_last)
        else $error("non-final character pending while idle");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("reset did not clear the handshake state");

endmodule

bind integer_to_padded_ascii i2a_chk u_i2a_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_char  (o_out_char),
    .i_out_last  (o_last_char)
);

`default_nettype wire
